// ----- src/gf5r_pkg.sv -----
// shared types, constants and gf(5) arithmetic for the rank block
`default_nettype none

package gf5r_pkg;

  localparam int unsigned RowW  = 24;
  localparam int unsigned DigW  = 3;
  localparam int unsigned RankW = 4;

  localparam logic [DigW-1:0] Gf5Mod = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic search;
    logic elim;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pivot_found;
    logic last_col;
  } sts_t;

  // fold raw digit 5..7 back into 0..2
  function automatic logic [DigW-1:0] reduce5(input logic [DigW-1:0] d);
    logic [DigW-1:0] r;
    if (d >= Gf5Mod) begin
      r = d - Gf5Mod;
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [DigW-1:0] mul5(input logic [DigW-1:0] a,
                                           input logic [DigW-1:0] b);
    logic [5:0]      p;
    logic [DigW-1:0] r;
    p = 6'(a) * 6'(b);
    priority if (p >= 6'd15) begin
      r = 3'(p - 6'd15);
    end else if (p >= 6'd10) begin
      r = 3'(p - 6'd10);
    end else if (p >= 6'd5) begin
      r = 3'(p - 6'd5);
    end else begin
      r = 3'(p);
    end
    return r;
  endfunction

  function automatic logic [DigW-1:0] sub5(input logic [DigW-1:0] a,
                                           input logic [DigW-1:0] b);
    logic [DigW-1:0] r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = 3'(4'(a) + 4'd5 - 4'(b));
    end
    return r;
  endfunction

  function automatic logic [DigW-1:0] inv5(input logic [DigW-1:0] a);
    logic [DigW-1:0] r;
    unique case (a)
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/gf5r_dp.sv -----
// datapath: row store, pivot search, row-parallel elimination, rank counter
`default_nettype none

module gf5r_dp #(
  parameter int unsigned SIZE = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire gf5r_pkg::cmd_t                   cmd_i,
  input  wire logic [gf5r_pkg::RowW-1:0]        row_digits_i,
  output gf5r_pkg::sts_t                        sts_o,
  output logic [gf5r_pkg::RankW-1:0]            rank_value_o
);

  localparam int unsigned IdxW = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int unsigned CntW = $clog2(SIZE + 1);
  localparam int unsigned DigW = gf5r_pkg::DigW;
  localparam int unsigned RankW = gf5r_pkg::RankW;

  logic [DigW-1:0]  m_q [SIZE][SIZE];
  logic [DigW-1:0]  m_d [SIZE][SIZE];
  logic [DigW-1:0]  prow_q [SIZE];
  logic [DigW-1:0]  prow_d [SIZE];
  logic [SIZE-1:0]  used_q, used_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  col_q, col_d;
  logic [IdxW-1:0]  piv_q, piv_d;
  logic [RankW-1:0] rank_q, rank_d;
  logic [RankW-1:0] rank_out_q, rank_out_d;

  logic             found;
  logic [IdxW-1:0]  sel;
  logic [DigW-1:0]  scale;

  // first unused row with a nonzero entry in the current column
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = SIZE - 1; i >= 0; i--) begin
      if (!used_q[i] && (m_q[i][col_q] != '0)) begin
        found = 1'b1;
        sel   = IdxW'(i);
      end
    end
  end

  assign scale = gf5r_pkg::inv5(m_q[sel][col_q]);

  assign sts_o.pivot_found = found;
  assign sts_o.last_col    = (col_q == IdxW'(SIZE - 1));

  always_comb begin
    m_d        = m_q;
    prow_d     = prow_q;
    used_d     = used_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    piv_d      = piv_q;
    rank_d     = rank_q;
    rank_out_d = rank_out_q;
    priority if (cmd_i.finish) begin
      rank_out_d = rank_q;
      for (int i = 0; i < SIZE; i++) begin
        for (int j = 0; j < SIZE; j++) begin
          m_d[i][j] = '0;
        end
      end
      used_d = '0;
      cnt_d  = '0;
      col_d  = '0;
      rank_d = '0;
    end else if (cmd_i.load) begin
      // rows past a full store are dropped
      if (cnt_q < CntW'(SIZE)) begin
        for (int j = 0; j < SIZE; j++) begin
          m_d[cnt_q[IdxW-1:0]][j] = gf5r_pkg::reduce5(row_digits_i[DigW*j +: DigW]);
        end
        cnt_d = cnt_q + CntW'(1);
      end
    end else if (cmd_i.search) begin
      if (found) begin
        piv_d = sel;
        for (int j = 0; j < SIZE; j++) begin
          prow_d[j] = gf5r_pkg::mul5(m_q[sel][j], scale);
        end
      end else begin
        col_d = col_q + IdxW'(1);
      end
    end else if (cmd_i.elim) begin
      for (int i = 0; i < SIZE; i++) begin
        if (!used_q[i] && (IdxW'(i) != piv_q)) begin
          for (int j = 0; j < SIZE; j++) begin
            m_d[i][j] = gf5r_pkg::sub5(m_q[i][j],
                                       gf5r_pkg::mul5(m_q[i][col_q], prow_q[j]));
          end
        end
      end
      used_d[piv_q] = 1'b1;
      rank_d        = rank_q + RankW'(1);
      col_d         = col_q + IdxW'(1);
    end else begin
      rank_out_d = rank_out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SIZE; i++) begin
        for (int j = 0; j < SIZE; j++) begin
          m_q[i][j] <= '0;
        end
      end
      used_q <= '0;
      cnt_q  <= '0;
      col_q  <= '0;
      rank_q <= '0;
    end else begin
      m_q    <= m_d;
      used_q <= used_d;
      cnt_q  <= cnt_d;
      col_q  <= col_d;
      rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prow_q     <= prow_d;
    piv_q      <= piv_d;
    rank_out_q <= rank_out_d;
  end

  assign rank_value_o = rank_out_q;

  a_rank_matches_pivots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(rank_q))
    else $error("rank count out of step with pivot rows");

  a_rank_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(rank_q) <= SIZE && int'(cnt_q) <= SIZE)
    else $error("rank or row count beyond matrix size");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> (cnt_q == '0) && (used_q == '0) && (rank_q == '0))
    else $error("store not cleared after result");

endmodule

`default_nettype wire

// ----- src/gf5r_ctrl.sv -----
// controller: load, per-column search and elimination, result hand-off
`default_nettype none

module gf5r_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           last_row_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire gf5r_pkg::sts_t sts_i,
  output gf5r_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    StLoad   = 4'b0001,
    StSearch = 4'b0010,
    StElim   = 4'b0100,
    StDone   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StLoad: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_row_i) begin
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        cmd_o.search = 1'b1;
        priority if (sts_i.pivot_found) begin
          state_d = StElim;
        end else if (sts_i.last_col) begin
          state_d = StDone;
        end else begin
          state_d = StSearch;
        end
      end
      StElim: begin
        cmd_o.elim = 1'b1;
        state_d    = sts_i.last_col ? StDone : StSearch;
      end
      StDone: begin
        // wait for the previous result to leave the output register
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_finish_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o)
    else $error("result not presented after finish");

  a_no_request_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> !cmd_o.load && in_stall_o)
    else $error("row taken during elimination");

  a_last_row_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load && last_row_i |=> state_q == StSearch)
    else $error("last row did not start elimination");

endmodule

`default_nettype wire

// ----- src/gf5_matrix_rank.sv -----
// top level: rank of a square matrix over gf(5)
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+----------------------------
//  rows in | in_valid_i | in_stall_o  | row_digits_i, last_row_i
//  rank out| out_valid_o| out_stall_i | rank_value_o
//
// row requests are taken while in_stall_o is low; after the last row the input stalls while
// the columns are worked: a column without a pivot gets a search step, one with a pivot a
// search and an elimination step, then the rank moves to the output register once free
// rows arrive freely while a rank waits to be taken; the next rank waits on it
// reset clears the row store, row count and rank counter; the store clears after each result
`default_nettype none

module gf5_matrix_rank #(
  parameter int unsigned SIZE = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [gf5r_pkg::RowW-1:0]     row_digits_i,
  input  wire logic                          last_row_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [gf5r_pkg::RankW-1:0]         rank_value_o
);

  gf5r_pkg::cmd_t cmd;
  gf5r_pkg::sts_t sts;

  gf5r_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_row_i  (last_row_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gf5r_dp #(
    .SIZE (SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .row_digits_i (row_digits_i),
    .sts_o        (sts),
    .rank_value_o (rank_value_o)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// testbench for gf5_matrix_rank: rows in, ranks checked against a gf(5) elimination predictor
`timescale 1ns / 100ps

module tb;

  localparam int unsigned Size       = 8;
  localparam int          Gf5        = 5;
  localparam int          IdlePct    = 30;
  localparam int          HoldCycles = 400;
  localparam int          ItemTarget = 550;
  localparam int          MaxReports = 10;
  localparam int          CycleLimit = 300000;
  // inverses of 0..4, three bits each
  localparam logic [14:0] Gf5Inverse = {3'd4, 3'd2, 3'd3, 3'd1, 3'd0};

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        in_valid_i   = 1'b0;
  logic                        in_stall_o;
  logic [gf5r_pkg::RowW-1:0]   row_digits_i = '0;
  logic                        last_row_i   = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i  = 1'b0;
  logic [gf5r_pkg::RankW-1:0]  rank_value_o;

  gf5_matrix_rank #(.SIZE(Size)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .row_digits_i(row_digits_i),
    .last_row_i  (last_row_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rank_value_o(rank_value_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [gf5r_pkg::RowW-1:0]  held_rows [Size];
  int unsigned                held_count = 0;
  logic [gf5r_pkg::RankW-1:0] expected_ranks [$];

  int  mismatches     = 0;
  int  items_sent     = 0;
  int  cycle_count    = 0;
  bit  sender_idles   = 1'b1;
  bit  receiver_idles = 1'b1;
  int  hold_len       = 0;
  int  hold_left      = 0;

  initial begin
    for (int i = 0; i < Size; i++) held_rows[i] = '0;
  end

  function automatic logic [gf5r_pkg::RankW-1:0] held_rank();
    int m [Size][Size];
    int rnk, piv, s, f, t;
    rnk = 0;
    for (int i = 0; i < Size; i++)
      for (int j = 0; j < Size; j++)
        m[i][j] = int'(held_rows[i][3*j +: 3]) % Gf5;
    for (int col = 0; col < Size; col++) begin
      piv = rnk;
      while (piv < Size && m[piv][col] == 0) piv++;
      if (piv < Size) begin
        for (int j = 0; j < Size; j++) begin
          t = m[rnk][j];
          m[rnk][j] = m[piv][j];
          m[piv][j] = t;
        end
        s = int'(Gf5Inverse[3*m[rnk][col] +: 3]);
        for (int j = 0; j < Size; j++) m[rnk][j] = (m[rnk][j] * s) % Gf5;
        for (int i = rnk + 1; i < Size; i++) begin
          f = m[i][col];
          for (int j = 0; j < Size; j++)
            m[i][j] = (m[i][j] + Gf5 * Gf5 - f * m[rnk][j]) % Gf5;
        end
        rnk++;
      end
    end
    return gf5r_pkg::RankW'(rnk);
  endfunction

  task automatic absorb_row(input logic [gf5r_pkg::RowW-1:0] row, input logic last);
    if (held_count < Size) begin
      held_rows[held_count] = row;
      held_count++;
    end
    if (last) begin
      expected_ranks = {expected_ranks, held_rank()};
      for (int i = 0; i < Size; i++) held_rows[i] = '0;
      held_count = 0;
    end
  endtask

  task automatic flag_mismatch(input string what, input int exp_v, input int got_v);
    mismatches++;
    if (mismatches <= MaxReports)
      $display("mismatch: %s, expected %0d, actual %0d", what, exp_v, got_v);
  endtask

  // one row request; optional idle gap first, garbage payload while idle
  task automatic send_row(input logic [gf5r_pkg::RowW-1:0] row, input logic last);
    int gap;
    if (sender_idles && $urandom_range(99) < IdlePct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i   <= 1'b0;
        row_digits_i <= gf5r_pkg::RowW'($urandom);
        last_row_i   <= 1'($urandom_range(1));
      end
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    row_digits_i <= row;
    last_row_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_row(row, last);
    items_sent++;
  endtask

  // random matrix of n rows; most rows are combinations of a few basis rows
  task automatic send_matrix(input int n_rows);
    logic [gf5r_pkg::RowW-1:0] basis [Size];
    logic [gf5r_pkg::RowW-1:0] row;
    int coef [Size];
    int basis_n, kind, acc, d;
    basis_n = $urandom_range(1, Size);
    for (int b = 0; b < Size; b++) basis[b] = gf5r_pkg::RowW'($urandom);
    for (int r = 0; r < n_rows; r++) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        row = '0;
      end else if (kind <= 2) begin
        row = gf5r_pkg::RowW'($urandom);
      end else begin
        for (int b = 0; b < basis_n; b++) coef[b] = $urandom_range(Gf5 - 1);
        for (int k = 0; k < Size; k++) begin
          acc = 0;
          for (int b = 0; b < basis_n; b++)
            acc += coef[b] * (int'(basis[b][3*k +: 3]) % Gf5);
          d = acc % Gf5;
          // residues 0..2 may also be written as 5..7
          if (d < 3 && $urandom_range(1)) d += Gf5;
          row[3*k +: 3] = 3'(d);
        end
      end
      send_row(row, r == n_rows - 1);
    end
  endtask

  function automatic int pick_rows();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return Size;
    if (sel < 88) return $urandom_range(1, Size - 1);
    return $urandom_range(Size + 1, Size + 3);
  endfunction

  // drop the request line first so the last row is not taken twice
  task automatic wait_ranks_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // identity gives full rank
    for (int i = 0; i < Size; i++)
      send_row(gf5r_pkg::RowW'(1) << (3 * i), i == Size - 1);
    send_row('0, 1'b1);
    send_row({gf5r_pkg::RowW{1'b1}}, 1'b1);
    // every digit 5, folds to zero
    send_row(24'hB6DB6D, 1'b1);
    // anti-diagonal needs row swaps, then one extra row and a last row past the full store
    for (int i = 0; i < Size; i++)
      send_row(gf5r_pkg::RowW'((i % 2) ? 6 : 4) << (3 * (Size - 1 - i)), 1'b0);
    send_row(gf5r_pkg::RowW'($urandom), 1'b0);
    send_row(gf5r_pkg::RowW'($urandom), 1'b1);
    wait_ranks_drained();
  endtask

  task automatic test_no_idle_burst();
    int stop_at;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    stop_at = items_sent + 100;
    while (items_sent < stop_at) send_matrix(pick_rows());
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_output_holdoff();
    @(posedge clk_i);
    hold_len = HoldCycles;
    // a rank waits at the output, the next matrix loads and its rank waits, stalling later rows
    repeat (3) send_matrix(Size);
    wait_ranks_drained();
  endtask

  task automatic test_pause_until_drained();
    repeat (2) begin
      repeat (3) send_matrix(pick_rows());
      wait_ranks_drained();
    end
  endtask

  task automatic test_random_traffic();
    while (items_sent < ItemTarget) send_matrix(pick_rows());
  endtask

  // receiver side
  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (receiver_idles) begin
      out_stall_i <= ($urandom_range(99) < IdlePct);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // rank checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ranks.size() == 0) begin
        flag_mismatch("rank with none pending", -1, int'(rank_value_o));
      end else begin
        if (rank_value_o !== expected_ranks[0])
          flag_mismatch("rank_value", int'(expected_ranks[0]), int'(rank_value_o));
        void'(expected_ranks.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_no_idle_burst();
    test_output_holdoff();
    test_pause_until_drained();
    test_random_traffic();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_ranks_drained();
    repeat (4 * Size) @(posedge clk_i);
    if (expected_ranks.size() != 0)
      flag_mismatch("ranks never returned", expected_ranks.size(), 0);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
